/* rtl/core/assert_macros.svh */
// Assertion macros shared by the closest factor pair RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CFP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/core/cfp_pkg.sv */
// Package for the closest factor pair block: field widths, defaults and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package cfp_pkg;

	// Widths of the transaction fields.
	localparam int VALUE_W = 32;
	localparam int SMALL_W = 16;
	localparam int LARGE_W = 32;

	// Default width of the number that is factored.
	localparam int VALUE_WIDTH_DEF = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture a new number, clear the root
		logic root_step;  // one digit of the square root
		logic div_start;  // start a trial division by the current candidate
		logic div_step;   // one quotient bit of the trial division
		logic dec;        // move to the next lower candidate
		logic out_load;   // write the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic d_zero;     // candidate divisor is zero
		logic rem_zero;   // last trial division left no remainder
		logic out_free;   // result register can take a new result now
	} stat_t;

endpackage

`default_nettype wire

/* rtl/core/closest_factor_pair.sv */
// Closest factor pair: finds the largest divisor not above the square root.
// Top level; depends on cfp_pkg, cfp_ctrl and cfp_dpath.
//
// Usage:
//   Input channel: value with in_valid / in_stall. A transaction is taken
//   when in_valid is high and in_stall is low.
//   Output channel: small_factor and large_factor with out_valid /
//   out_stall. Exactly one result comes out for each input transaction.
// Sequence:
//   A square root pass runs first, one digit per cycle. Each candidate
//   divisor is then tried in the restoring divider, one quotient bit per
//   cycle, and candidates are tried from the root downward. Then the
//   result register is written once it is free.
//   One number is worked on at a time; in_stall is high from acceptance
//   until the result is written into the output register.
// Reset and stall:
//   arst_n clears the controller and the output valid; no result is pending.
//   While out_stall is high the result holds, a new number may already be
//   accepted, and its result waits until the register is taken.
`default_nettype none

module closest_factor_pair #(
	parameter int VALUE_WIDTH = cfp_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [cfp_pkg::VALUE_W-1:0]  value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [cfp_pkg::SMALL_W-1:0]       small_factor,
	output logic [cfp_pkg::LARGE_W-1:0]       large_factor
);
	import cfp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer.
	cfp_ctrl #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic and result register.
	cfp_dpath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.cmd          (cmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.small_factor (small_factor),
		.large_factor (large_factor)
	);

endmodule

`default_nettype wire

/* rtl/core/cfp_ctrl.sv */
// Controller of the closest factor pair block: sequences the square root,
// the trial divisions and the result write. Depends on cfp_pkg.
`default_nettype none
`include "assert_macros.svh"

module cfp_ctrl #(
	parameter int VALUE_WIDTH = cfp_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire cfp_pkg::stat_t stat,
	output cfp_pkg::cmd_t      cmd
);
	import cfp_pkg::*;

	localparam int RW = (VALUE_WIDTH + 1) / 2;
	localparam int CW = $clog2(VALUE_WIDTH);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_ROOT   = 6'b000010,
		ST_CHECK  = 6'b000100,
		ST_DIVIDE = 6'b001000,
		ST_TEST   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Next state, step counter and commands.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_ROOT;
				end
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CW'(RW - 1)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.d_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cnt_d         = '0;
					state_d       = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CW'(VALUE_WIDTH - 1)) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (stat.rem_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.dec = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// A result is only written into a free result register.
	`CFP_ASSERT(a_out_load_free, cmd.out_load |-> stat.out_free, "result written while busy")
	// Each accepted transaction starts with a square root pass.
	`CFP_ASSERT(a_accept_root, accept |=> (state_q == ST_ROOT) && (cnt_q == '0),
		"accepted transaction did not start the root")

endmodule

`default_nettype wire

/* rtl/core/cfp_dpath.sv */
// Datapath of the closest factor pair block: bitwise square root, restoring
// divider, candidate register and result register. Depends on cfp_pkg.
`default_nettype none
`include "assert_macros.svh"

module cfp_dpath #(
	parameter int VALUE_WIDTH = cfp_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [cfp_pkg::VALUE_W-1:0]  value,
	input  wire cfp_pkg::cmd_t                cmd,
	output cfp_pkg::stat_t                    stat,
	input  wire logic                         out_stall,
	output logic                              out_valid,
	output logic [cfp_pkg::SMALL_W-1:0]       small_factor,
	output logic [cfp_pkg::LARGE_W-1:0]       large_factor
);
	import cfp_pkg::*;

	localparam int RW = (VALUE_WIDTH + 1) / 2;

	logic [VALUE_WIDTH-1:0] n_q;     // number being factored
	logic [2*RW-1:0]        sx_q;    // number shifted out two bits per root step
	logic [RW-1:0]          d_q;     // root, then candidate divisor
	logic [RW:0]            rem_q;   // root or division remainder
	logic [VALUE_WIDTH-1:0] qs_q;    // dividend shifting out, quotient shifting in
	logic                   out_valid_q;
	logic [SMALL_W-1:0]     small_q;
	logic [LARGE_W-1:0]     large_q;

	logic [RW+2:0]          root_cat;
	logic [RW+2:0]          root_trial;
	logic                   root_fit;
	logic [RW+1:0]          div_cat;
	logic                   div_fit;

	// One square root digit: try subtracting 4*root + 1.
	always_comb begin
		root_cat   = {rem_q, sx_q[2*RW-1 -: 2]};
		root_trial = (RW + 3)'({d_q, 2'b01});
		root_fit   = (root_cat >= root_trial);
	end

	// One quotient bit: shift in the next dividend bit and compare.
	always_comb begin
		div_cat = {rem_q, qs_q[VALUE_WIDTH-1]};
		div_fit = (div_cat >= (RW + 2)'(d_q));
	end

	// Shared arithmetic registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= VALUE_WIDTH'(value);
			sx_q  <= (2 * RW)'(VALUE_WIDTH'(value));
			d_q   <= '0;
			rem_q <= '0;
		end else if (cmd.root_step) begin
			sx_q <= {sx_q[2*RW-3:0], 2'b00};
			if (root_fit) begin
				rem_q <= (RW + 1)'(root_cat - root_trial);
				d_q   <= {d_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= (RW + 1)'(root_cat);
				d_q   <= {d_q[RW-2:0], 1'b0};
			end
		end else if (cmd.div_start) begin
			rem_q <= '0;
			qs_q  <= n_q;
		end else if (cmd.div_step) begin
			qs_q <= {qs_q[VALUE_WIDTH-2:0], div_fit};
			if (div_fit) begin
				rem_q <= (RW + 1)'(div_cat - (RW + 2)'(d_q));
			end else begin
				rem_q <= (RW + 1)'(div_cat);
			end
		end else if (cmd.dec) begin
			d_q <= d_q - 1'b1;
		end
	end

	assign stat.d_zero   = (d_q == '0);
	assign stat.rem_zero = (rem_q == '0);
	assign stat.out_free = !out_valid_q || !out_stall;

	// Result register: the valid bit drops when the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: no divisor found means the pair (1, n).
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (d_q == '0) begin
				small_q <= SMALL_W'(1);
				large_q <= LARGE_W'(n_q);
			end else begin
				small_q <= SMALL_W'(d_q);
				large_q <= LARGE_W'(qs_q);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign small_factor = small_q;
	assign large_factor = large_q;

	// A found divisor must have divided the number exactly.
	`CFP_ASSERT(a_found_exact, (cmd.out_load && (d_q != '0)) |-> (rem_q == '0),
		"result from an inexact division")
	// Stepping down moves the candidate by exactly one.
	`CFP_ASSERT(a_dec_one, cmd.dec |=> (d_q == $past(d_q) - 1'b1),
		"candidate did not step down by one")
	// A zero candidate is never used as a divisor.
	`CFP_ASSERT_NEVER(a_no_div_zero, cmd.div_start && (d_q == '0), "division by zero started")

endmodule

`default_nettype wire

/* verif/closest_factor_pair_tb.sv */
// Self-checking testbench for closest_factor_pair: drives numbers, predicts each factor pair
// and compares it with the result channel. Depends on cfp_pkg and the closest_factor_pair RTL.
`default_nettype none

module closest_factor_pair_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_WIDTH = cfp_pkg::VALUE_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 200;

	typedef logic [cfp_pkg::VALUE_W-1:0] value_t;
	typedef logic [cfp_pkg::SMALL_W-1:0] small_t;
	typedef logic [cfp_pkg::LARGE_W-1:0] large_t;

	// One expected factor pair.
	typedef struct {
		small_t small_f;
		large_t large_f;
	} factor_pair_t;

	// Holds the factor pairs still owed by the block and checks each result against them.
	class factor_pair_checker;
		factor_pair_t pairs_due[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Prints one mismatch line and counts it.
		task report(input string msg);
			$display("%0t ns mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// Exact integer floor square root, one result bit per pass.
		function longint unsigned floor_root(input longint unsigned v);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		// Largest divisor not above the root, and its cofactor.
		function factor_pair_t closest_pair(input value_t v);
			longint unsigned mask;
			longint unsigned n;
			longint unsigned sm;
			longint unsigned lg;
			longint unsigned d;
			factor_pair_t p;
			mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 1);
			n = longint'(v) & mask;
			sm = 1;
			lg = n;
			for (d = floor_root(n); d > 0; d--) begin
				if (n % d == 0) begin
					sm = d;
					lg = n / d;
					break;
				end
			end
			p.small_f = sm[cfp_pkg::SMALL_W-1:0];
			p.large_f = lg[cfp_pkg::LARGE_W-1:0];
			return p;
		endfunction

		// An input transaction was accepted: queue its factor pair.
		function void note_value(input value_t v);
			pairs_due.push_back(closest_pair(v));
		endfunction

		// A result transaction was accepted: compare it with the oldest pair owed.
		task check_pair(input small_t sm, input large_t lg);
			factor_pair_t exp_p;
			if (pairs_due.size() == 0) begin
				report($sformatf("result (%0d, %0d) with no transaction waiting", sm, lg));
			end else begin
				exp_p = pairs_due.pop_front();
				if (sm !== exp_p.small_f)
					report($sformatf("small_factor %0d, wanted %0d", sm, exp_p.small_f));
				if (lg !== exp_p.large_f)
					report($sformatf("large_factor %0d, wanted %0d", lg, exp_p.large_f));
			end
		endtask

		function int due();
			return pairs_due.size();
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	value_t value = '0;
	logic   out_stall = 1'b0;
	logic   in_stall;
	logic   out_valid;
	small_t small_factor;
	large_t large_factor;

	// Set during a stretch of the random part in which neither side idles.
	bit calm = 1'b0;
	int unsigned cycles = 0;

	factor_pair_checker board = new();

	closest_factor_pair #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.small_factor(small_factor),
		.large_factor(large_factor)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle count and timeout.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("closest_factor_pair_tb: FAIL");
			$finish;
		end
	end

	// Result side: take accepted results and stall at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_pair(small_factor, large_factor);
			out_stall <= !calm && ($urandom_range(0, 99) < 28);
		end
	end

	// Presents one number, idling first at random, and returns at the edge it is taken.
	task automatic send_value(input value_t v);
		while (!calm && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (in_stall);
		board.note_value(v);
	endtask

	// Holds the sender off until every owed result has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (board.due() != 0)
			@(posedge clk);
	endtask

	// A product of two nearby factors, so the downward search stays short.
	function automatic value_t near_square();
		longint unsigned a;
		longint unsigned b;
		longint unsigned t;
		a = $urandom_range(2, 65535);
		t = $urandom_range(0, 64);
		b = a + t;
		if (a * b > 64'hFFFF_FFFF)
			b = a - t;
		return value_t'(a * b);
	endfunction

	initial begin
		value_t directed[$];
		value_t v;
		int pick;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero, one, small primes and composites, a mid prime, exact squares, all ones.
		directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd7, 32'd12, 32'd16,
			32'd65535, 32'd65521, 32'd65536, 32'd1000003, 32'h4000_0000,
			32'hFFFE_0001, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0001_0001};
		foreach (directed[i])
			send_value(directed[i]);
		wait_for_results();

		// Random part: mostly near-square products, some small and masked numbers.
		for (int i = 0; i < 100; i++) begin
			calm = (i >= 40 && i < 65);
			if (i == 70)
				wait_for_results();
			pick = $urandom_range(0, 99);
			if (pick < 70)
				v = near_square();
			else if (pick < 90)
				v = value_t'($urandom_range(0, 4095));
			else
				v = value_t'($urandom & ((32'd1 << $urandom_range(1, 16)) - 1));
			send_value(v);
		end
		calm = 1'b0;
		wait_for_results();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.due() != 0)
			board.report($sformatf("%0d results never came", board.due()));
		if (board.errors == 0)
			$display("closest_factor_pair_tb: PASS");
		else
			$display("closest_factor_pair_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
